[sv/dfla_pkg.sv]
// Shared constants and register indexes for the descriptor free list allocator.
`default_nettype none

package dfla_pkg;

  // Number of descriptor slots on the free list
  localparam int CAPACITY  = 1024;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int DEPTH_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W    = 64;
  localparam int STEP_W    = 13;
  // Width of an offset that still maps to a slot index below 2**IDX_W
  localparam int REM_W     = STEP_W + IDX_W;
  localparam int CNT_W     = $clog2(IDX_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(32);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

`default_nettype wire

[sv/descriptor_free_list_allocator.sv]
// LIFO free list slot allocator with an iterative address-to-index divider.
// Allocate: read, multiply, two shared adds. Free: subtract, range check, then the
//   one-bit-per-cycle divider and push; an out-of-range free skips the divider, and an
//   empty, full or step-zero refusal goes straight to the result. Reset: list full, slot 0
//   on top, step 32. Throughput: one request at a time; the next is taken the cycle after
//   the result is registered, even while it waits on out_ready.
`default_nettype none

module descriptor_free_list_allocator (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [dfla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [dfla_pkg::ADDR_W-1:0]        cfg_data,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               op,
  input  wire [dfla_pkg::ADDR_W-1:0]        free_address,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic                              ok,
  output logic [dfla_pkg::ADDR_W-1:0]       cpu_address,
  output logic [dfla_pkg::ADDR_W-1:0]       gpu_address,
  output logic [dfla_pkg::DEPTH_W-1:0]      free_slots
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ADDC = 4'd3;
  localparam logic [3:0] S_ADDG = 4'd4;
  localparam logic [3:0] S_SUB  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_PUSH = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]                      state;
  logic [dfla_pkg::ADDR_W-1:0]     cpu_base;
  logic [dfla_pkg::ADDR_W-1:0]     gpu_base;
  logic [dfla_pkg::STEP_W-1:0]     step;
  logic [dfla_pkg::DEPTH_W-1:0]    depth;
  logic [dfla_pkg::DEPTH_W-1:0]    low_mark;
  logic [dfla_pkg::ADDR_W-1:0]     addr;
  logic [dfla_pkg::ADDR_W-1:0]     diff;
  logic [dfla_pkg::REM_W-1:0]      rem;
  logic [dfla_pkg::REM_W-1:0]      divisor;
  logic [dfla_pkg::IDX_W-1:0]      quot;
  logic [dfla_pkg::CNT_W-1:0]      cnt;
  logic [dfla_pkg::REM_W-1:0]      prod;
  logic                            r_ok;
  logic [dfla_pkg::ADDR_W-1:0]     r_cpu;
  logic [dfla_pkg::ADDR_W-1:0]     r_gpu;

  logic [dfla_pkg::IDX_W-1:0]      mem [dfla_pkg::CAPACITY];
  logic [dfla_pkg::IDX_W-1:0]      rd_q;

  logic [dfla_pkg::DEPTH_W-1:0]    depth_m1;
  logic [dfla_pkg::IDX_W-1:0]      rd_pos;
  logic [dfla_pkg::IDX_W-1:0]      wr_pos;
  logic [dfla_pkg::IDX_W-1:0]      slot;
  logic                            mem_we;
  logic                            quot_ok;
  logic                            rem_ge;
  logic                            in_range;
  logic [dfla_pkg::REM_W-1:0]      limit;
  logic [dfla_pkg::ADDR_W-1:0]     add_a;
  logic [dfla_pkg::ADDR_W-1:0]     add_b;
  logic                            add_sub;
  logic [dfla_pkg::ADDR_W-1:0]     add_sum;
  logic                            out_free;

  // Stack pointers and slot selection
  always_comb begin
    depth_m1 = depth - dfla_pkg::DEPTH_W'(1);
    rd_pos   = depth_m1[dfla_pkg::IDX_W-1:0];
    wr_pos   = depth[dfla_pkg::IDX_W-1:0];
    // Entries below the low-water mark were never written since reset
    if (depth_m1 >= low_mark) begin
      slot = rd_q;
    end else begin
      slot = dfla_pkg::IDX_W'(dfla_pkg::CAPACITY - 1) - rd_pos;
    end
    quot_ok = {1'b0, quot} < dfla_pkg::DEPTH_W'(dfla_pkg::CAPACITY);
    mem_we  = (state == S_PUSH) && quot_ok;
    rem_ge  = rem >= divisor;
    limit   = {step, {dfla_pkg::IDX_W{1'b0}}};
    in_range = (diff[dfla_pkg::ADDR_W-1:dfla_pkg::REM_W] == '0) &&
               (diff[dfla_pkg::REM_W-1:0] < limit);
    out_free = !out_valid || out_ready;
    in_ready = (state == S_IDLE);
  end

  // Shared 64-bit adder: offset subtract for free, base adds for allocate
  always_comb begin
    case (state)
      S_SUB: begin
        add_a   = addr;
        add_b   = cpu_base;
        add_sub = 1'b1;
      end
      S_ADDG: begin
        add_a   = gpu_base;
        add_b   = {{(dfla_pkg::ADDR_W-dfla_pkg::REM_W){1'b0}}, prod};
        add_sub = 1'b0;
      end
      default: begin
        add_a   = cpu_base;
        add_b   = {{(dfla_pkg::ADDR_W-dfla_pkg::REM_W){1'b0}}, prod};
        add_sub = 1'b0;
      end
    endcase
    add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(dfla_pkg::ADDR_W-1){1'b0}}, add_sub};
  end

  // Free list memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_pos] <= quot;
    end
    rd_q <= mem[rd_pos];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_base <= '0;
      gpu_base <= '0;
      step     <= dfla_pkg::STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dfla_pkg::REG_CPU_BASE: cpu_base <= cfg_data;
        dfla_pkg::REG_GPU_BASE: gpu_base <= cfg_data;
        dfla_pkg::REG_STEP:     step     <= cfg_data[dfla_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= dfla_pkg::DEPTH_W'(dfla_pkg::CAPACITY);
      low_mark  <= dfla_pkg::DEPTH_W'(dfla_pkg::CAPACITY);
      out_valid <= 1'b0;
    end else begin
      // Drop a delivered result unless the next one loads in its place
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            addr  <= free_address;
            r_ok  <= 1'b0;
            r_cpu <= '0;
            r_gpu <= '0;
            if (op == dfla_pkg::OP_ALLOC) begin
              state <= (depth == '0) ? S_DONE : S_READ;
            end else if (step == '0 ||
                         depth == dfla_pkg::DEPTH_W'(dfla_pkg::CAPACITY)) begin
              state <= S_DONE;
            end else begin
              state <= S_SUB;
            end
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          // Pop the top slot and scale it by the step
          prod  <= {{(dfla_pkg::REM_W-dfla_pkg::IDX_W){1'b0}}, slot} *
                   {{(dfla_pkg::REM_W-dfla_pkg::STEP_W){1'b0}}, step};
          depth <= depth_m1;
          if (depth_m1 < low_mark) begin
            low_mark <= depth_m1;
          end
          state <= S_ADDC;
        end
        S_ADDC: begin
          r_cpu <= add_sum;
          state <= S_ADDG;
        end
        S_ADDG: begin
          r_gpu <= add_sum;
          r_ok  <= 1'b1;
          state <= S_DONE;
        end
        S_SUB: begin
          diff  <= add_sum;
          state <= S_CHK;
        end
        S_CHK: begin
          rem     <= diff[dfla_pkg::REM_W-1:0];
          divisor <= {1'b0, step, {(dfla_pkg::IDX_W-1){1'b0}}};
          cnt     <= '0;
          state   <= in_range ? S_DIV : S_DONE;
        end
        S_DIV: begin
          // Retire one quotient bit, most significant first
          if (rem_ge) begin
            rem <= rem - divisor;
          end
          quot    <= {quot[dfla_pkg::IDX_W-2:0], rem_ge};
          divisor <= divisor >> 1;
          cnt     <= cnt + dfla_pkg::CNT_W'(1);
          if (cnt == dfla_pkg::CNT_W'(dfla_pkg::IDX_W - 1)) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (quot_ok) begin
            depth <= depth + dfla_pkg::DEPTH_W'(1);
            r_ok  <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            ok          <= r_ok;
            cpu_address <= r_cpu;
            gpu_address <= r_gpu;
            free_slots  <= depth;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Stack depth never passes the capacity
  a_depth_max: assert property (@(posedge clk) disable iff (rst)
    depth <= dfla_pkg::DEPTH_W'(dfla_pkg::CAPACITY))
    else $error("stack depth above capacity");

  // Low-water mark never sits above the current depth
  a_low_mark: assert property (@(posedge clk) disable iff (rst)
    low_mark <= depth)
    else $error("low-water mark above depth");

  // A failed request carries zero addresses
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (cpu_address == '0 && gpu_address == '0))
    else $error("failed request with nonzero address");

  // A successful free leaves one more slot on the list
  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && quot_ok) |=> (depth == $past(depth) + dfla_pkg::DEPTH_W'(1)))
    else $error("push did not grow the list");

endmodule

`default_nettype wire
